### src/assert_macros.svh
// Assertion helpers shared by the nlerp pipeline modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define QNL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define QNL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

### src/qnl_pkg.sv
package qnl_pkg;

   // Fixed field widths
   localparam int COMPONENT_WIDTH       = 16;
   localparam int FRACTION_BITS_DEFAULT = 14;
   localparam int FRAC_WIDTH            = 16;
   localparam int FRAC_SHIFT            = 15;
   localparam logic [FRAC_WIDTH-1:0] FRAC_ONE = 16'h8000;

   // Internal widths
   localparam int PROD_WIDTH  = 2 * COMPONENT_WIDTH;
   localparam int DOT_WIDTH   = 2 * COMPONENT_WIDTH + 2;
   localparam int BLEND_WIDTH = COMPONENT_WIDTH + 18;
   localparam int SUMSQ_WIDTH = 2 * COMPONENT_WIDTH;

   typedef logic signed [COMPONENT_WIDTH-1:0] comp_type;

   typedef struct packed {
      comp_type                prev_i;
      comp_type                prev_j;
      comp_type                prev_k;
      comp_type                prev_w;
      comp_type                cur_i;
      comp_type                cur_j;
      comp_type                cur_k;
      comp_type                cur_w;
      logic [FRAC_WIDTH-1:0]   fraction;
   } req_type;

   typedef struct packed {
      comp_type out_i;
      comp_type out_j;
      comp_type out_k;
      comp_type out_w;
      logic     degenerate;
   } rsp_type;

   // Rounded blend that rides along the square-root pipeline
   typedef struct packed {
      logic [3:0][COMPONENT_WIDTH-1:0] comp;
      logic                            degenerate;
   } blend_type;

   // Per-item control that rides along the divider pipeline
   typedef struct packed {
      logic [3:0] neg;
      logic       degenerate;
   } div_side_type;

endpackage

### src/qnl_isqrt.sv
`include "assert_macros.svh"

// Pipelined integer square root, one root bit per stage.
module qnl_isqrt #(
   parameter int ROOT_WIDTH = qnl_pkg::COMPONENT_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [2*ROOT_WIDTH-1:0]   in_value,
   input  qnl_pkg::blend_type        in_side,
   output logic                      out_valid,
   output logic [ROOT_WIDTH-1:0]     out_root,
   output qnl_pkg::blend_type        out_side
);

   localparam int RW  = ROOT_WIDTH;
   localparam int SQW = 2 * RW + 1;

   logic                valid_ff [RW];
   logic [RW:0]         rem_ff   [RW];
   logic [RW-1:0]       root_ff  [RW];
   logic [2*RW-1:0]     value_ff [RW];
   qnl_pkg::blend_type  side_ff  [RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int K = RW - 1 - s;

      logic               pv;
      logic [RW:0]        prem;
      logic [RW-1:0]      proot;
      logic [2*RW-1:0]    pval;
      qnl_pkg::blend_type pside;
      logic [RW+2:0]      rem_sh;
      logic [RW+2:0]      trial;
      logic [RW:0]        rem_in;
      logic [RW-1:0]      root_in;

      // stage input: ports for the first stage, previous stage otherwise
      if (s == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = '0;
         assign proot = '0;
         assign pval  = in_value;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = valid_ff[s-1];
         assign prem  = rem_ff[s-1];
         assign proot = root_ff[s-1];
         assign pval  = value_ff[s-1];
         assign pside = side_ff[s-1];
      end

      // bring down two radicand bits, try root bit one
      always_comb begin
         rem_sh = {prem, pval[2*K+1 -: 2]};
         trial  = (RW+3)'({proot, 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = RW'(0) + (RW+1)'(rem_sh - trial);
            root_in = {proot[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RW:0];
            root_in = {proot[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]   <= rem_in;
         root_ff[s]  <= root_in;
         value_ff[s] <= pval;
         side_ff[s]  <= pside;
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

   // root is the floor of the square root of the value it came with
   `QNL_ASSERT_IMP(a_root_floor, clock, reset, out_valid, (SQW'(out_root) * SQW'(out_root) <= SQW'(value_ff[RW-1])) && ((SQW'(out_root) + SQW'(1)) * (SQW'(out_root) + SQW'(1)) > SQW'(value_ff[RW-1])), "square root is not the floor root")

endmodule

### src/qnl_div.sv
`include "assert_macros.svh"

// Four-lane pipelined restoring divider, one quotient bit per stage.
// The quotient of each lane is known to fit FRACTION_BITS+1 bits.
module qnl_div #(
   parameter int ROOT_WIDTH    = qnl_pkg::COMPONENT_WIDTH,
   parameter int FRACTION_BITS = qnl_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [ROOT_WIDTH-1:0]                         in_root,
   input  logic [3:0][ROOT_WIDTH+FRACTION_BITS-1:0]      in_num,
   input  qnl_pkg::div_side_type                         in_side,
   output logic                                          out_valid,
   output logic [3:0][FRACTION_BITS:0]                   out_quot,
   output qnl_pkg::div_side_type                         out_side
);

   localparam int CW = ROOT_WIDTH;
   localparam int Q  = FRACTION_BITS + 1;
   localparam int NW = ROOT_WIDTH + FRACTION_BITS;
   localparam logic [Q-1:0] QMAX = {1'b1, {FRACTION_BITS{1'b0}}};

   logic                    valid_ff [Q];
   logic [CW-1:0]           root_ff  [Q];
   logic [3:0][NW-1:0]      num_ff   [Q];
   logic [3:0][CW-1:0]      rem_ff   [Q];
   logic [3:0][Q-1:0]       quot_ff  [Q];
   qnl_pkg::div_side_type   side_ff  [Q];

   for (genvar j = 0; j < Q; j++) begin : g_stage
      localparam int BI = Q - 1 - j;

      logic                  pv;
      logic [CW-1:0]         proot;
      logic [3:0][NW-1:0]    pnum;
      logic [3:0][CW-1:0]    prem;
      logic [3:0][Q-1:0]     pquot;
      qnl_pkg::div_side_type pside;
      logic [CW:0]           rem_sh [4];
      logic [3:0][CW-1:0]    rem_in;
      logic [3:0][Q-1:0]     quot_in;

      // first stage starts from the numerator bits above the quotient
      if (j == 0) begin : g_first
         assign pv    = in_valid;
         assign proot = in_root;
         assign pnum  = in_num;
         assign pside = in_side;
         for (genvar n = 0; n < 4; n++) begin : g_lane
            assign prem[n]  = CW'(in_num[n][NW-1:Q]);
            assign pquot[n] = '0;
         end
      end else begin : g_next
         assign pv    = valid_ff[j-1];
         assign proot = root_ff[j-1];
         assign pnum  = num_ff[j-1];
         assign prem  = rem_ff[j-1];
         assign pquot = quot_ff[j-1];
         assign pside = side_ff[j-1];
      end

      // shift in one numerator bit, subtract the divisor when it fits
      always_comb begin
         for (int n = 0; n < 4; n++) begin
            rem_sh[n] = {prem[n], pnum[n][BI]};
            if (rem_sh[n] >= {1'b0, proot}) begin
               rem_in[n]  = CW'(rem_sh[n] - {1'b0, proot});
               quot_in[n] = {pquot[n][Q-2:0], 1'b1};
            end else begin
               rem_in[n]  = rem_sh[n][CW-1:0];
               quot_in[n] = {pquot[n][Q-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         root_ff[j] <= proot;
         num_ff[j]  <= pnum;
         rem_ff[j]  <= rem_in;
         quot_ff[j] <= quot_in;
         side_ff[j] <= pside;
      end
   end

   assign out_valid = valid_ff[Q-1];
   assign out_quot  = quot_ff[Q-1];
   assign out_side  = side_ff[Q-1];

   // a normalized component never exceeds one
   `QNL_ASSERT_IMP(a_quot_unit, clock, reset, out_valid && !out_side.degenerate, (out_quot[0] <= QMAX) && (out_quot[1] <= QMAX) && (out_quot[2] <= QMAX) && (out_quot[3] <= QMAX), "normalized component above one")

endmodule

### src/quaternion_nlerp_normalize.sv
// Pipeline from start to rsp_valid: six arithmetic stages, one square-root stage per root bit,
//   one divider stage per quotient bit, plus numerator and output registers.
// Throughput: one transfer per cycle while busy is low; results cannot be held off by the receiver.
// Reset (synchronous): clears every valid bit; busy is high during reset and in the cycle after it.
`include "assert_macros.svh"

module quaternion_nlerp_normalize #(
   parameter int FRACTION_BITS = qnl_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  qnl_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output qnl_pkg::rsp_type rsp_data
);

   localparam int CW      = qnl_pkg::COMPONENT_WIDTH;
   localparam int PW      = qnl_pkg::PROD_WIDTH;
   localparam int DW      = qnl_pkg::DOT_WIDTH;
   localparam int BW      = qnl_pkg::BLEND_WIDTH;
   localparam int SW      = qnl_pkg::SUMSQ_WIDTH;
   localparam int FW      = qnl_pkg::FRAC_WIDTH;
   localparam int Q       = FRACTION_BITS + 1;
   localparam int NW      = CW + FRACTION_BITS;
   localparam int XW      = (Q > CW) ? Q : CW;
   localparam int LATENCY = CW + Q + 8;
   localparam int F_TO_OUT = CW + Q + 2;

   localparam logic signed [BW-1:0] ROUND_HALF = BW'(1 << (qnl_pkg::FRAC_SHIFT - 1));
   localparam logic signed [BW-1:0] LIM_W      = BW'((1 << (CW - 1)) - 1);
   localparam qnl_pkg::comp_type    LIM_C      = CW'((1 << (CW - 1)) - 1);
   localparam logic [CW-1:0]        IDENT_W    = CW'(64'd1 << FRACTION_BITS);

   logic accept;

   // busy only around reset
   logic busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // ---------------- stage A: fraction clamp, dot-product terms
   qnl_pkg::comp_type        p_req [4];
   qnl_pkg::comp_type        c_req [4];
   logic [FW-1:0]            a_f_in;
   logic signed [PW-1:0]     a_pc_in [4];

   logic                     a_valid_ff;
   qnl_pkg::comp_type        a_p_ff  [4];
   qnl_pkg::comp_type        a_c_ff  [4];
   logic [FW-1:0]            a_f_ff;
   logic signed [PW-1:0]     a_pc_ff [4];

   always_comb begin
      p_req[0] = req_data.prev_i;
      p_req[1] = req_data.prev_j;
      p_req[2] = req_data.prev_k;
      p_req[3] = req_data.prev_w;
      c_req[0] = req_data.cur_i;
      c_req[1] = req_data.cur_j;
      c_req[2] = req_data.cur_k;
      c_req[3] = req_data.cur_w;
      a_f_in = (req_data.fraction > qnl_pkg::FRAC_ONE) ? qnl_pkg::FRAC_ONE
                                                       : req_data.fraction;
      for (int n = 0; n < 4; n++) begin
         a_pc_in[n] = p_req[n] * c_req[n];
      end
   end

   // ---------------- stage B: dot sign, blend weights
   logic signed [DW-1:0]     b_dot;
   logic signed [FW:0]       b_fx;
   logic signed [FW:0]       b_omt_in;
   logic signed [FW:0]       b_t_in;

   logic                     b_valid_ff;
   qnl_pkg::comp_type        b_p_ff [4];
   qnl_pkg::comp_type        b_c_ff [4];
   logic signed [FW:0]       b_omt_ff;
   logic signed [FW:0]       b_t_ff;

   always_comb begin
      b_dot = DW'(a_pc_ff[0]) + DW'(a_pc_ff[1]) + DW'(a_pc_ff[2]) + DW'(a_pc_ff[3]);
      b_fx     = $signed({1'b0, a_f_ff});
      b_omt_in = $signed({1'b0, qnl_pkg::FRAC_ONE - a_f_ff});
      // shorter arc: negate the fraction when the dot product is negative
      b_t_in   = b_dot[DW-1] ? -b_fx : b_fx;
   end

   // ---------------- stage C: weighted products
   logic signed [CW+FW:0]    c_pp_in [4];
   logic signed [CW+FW:0]    c_cp_in [4];

   logic                     c_valid_ff;
   logic signed [CW+FW:0]    c_pp_ff [4];
   logic signed [CW+FW:0]    c_cp_ff [4];

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         c_pp_in[n] = b_p_ff[n] * b_omt_ff;
         c_cp_in[n] = b_c_ff[n] * b_t_ff;
      end
   end

   // ---------------- stage D: blend sum, round half up, saturate
   logic signed [BW-1:0]     d_sum [4];
   logic signed [BW-1:0]     d_rnd [4];
   qnl_pkg::comp_type        d_b_in [4];

   logic                     d_valid_ff;
   qnl_pkg::comp_type        d_b_ff [4];

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         d_sum[n] = BW'(c_pp_ff[n]) + BW'(c_cp_ff[n]) + ROUND_HALF;
         d_rnd[n] = d_sum[n] >>> qnl_pkg::FRAC_SHIFT;
         if (d_rnd[n] > LIM_W) begin
            d_b_in[n] = LIM_C;
         end else if (d_rnd[n] < -LIM_W) begin
            d_b_in[n] = -LIM_C;
         end else begin
            d_b_in[n] = d_rnd[n][CW-1:0];
         end
      end
   end

   // ---------------- stage E: squares
   logic signed [PW-1:0]     e_sq_in [4];

   logic                     e_valid_ff;
   logic [SW-1:0]            e_sq_ff [4];
   qnl_pkg::comp_type        e_b_ff  [4];

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         e_sq_in[n] = d_b_ff[n] * d_b_ff[n];
      end
   end

   // ---------------- stage F: squared length, zero test
   logic [SW-1:0]            f_s_in;
   qnl_pkg::blend_type       f_blend_in;

   logic                     f_valid_ff;
   logic [SW-1:0]            f_s_ff;
   qnl_pkg::blend_type       f_blend_ff;

   always_comb begin
      f_s_in = e_sq_ff[0] + e_sq_ff[1] + e_sq_ff[2] + e_sq_ff[3];
      for (int n = 0; n < 4; n++) begin
         f_blend_in.comp[n] = e_b_ff[n];
      end
      f_blend_in.degenerate = (f_s_in == '0);
   end

   // stages A..F registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < 4; n++) begin
         a_p_ff[n]  <= p_req[n];
         a_c_ff[n]  <= c_req[n];
         a_pc_ff[n] <= a_pc_in[n];
         b_p_ff[n]  <= a_p_ff[n];
         b_c_ff[n]  <= a_c_ff[n];
         c_pp_ff[n] <= c_pp_in[n];
         c_cp_ff[n] <= c_cp_in[n];
         d_b_ff[n]  <= d_b_in[n];
         e_sq_ff[n] <= $unsigned(e_sq_in[n]);
         e_b_ff[n]  <= d_b_ff[n];
      end
      a_f_ff     <= a_f_in;
      b_omt_ff   <= b_omt_in;
      b_t_ff     <= b_t_in;
      f_s_ff     <= f_s_in;
      f_blend_ff <= f_blend_in;
   end

   // ---------------- length
   logic                  sq_valid;
   logic [CW-1:0]         sq_root;
   qnl_pkg::blend_type    sq_side;

   qnl_isqrt #(
      .ROOT_WIDTH (CW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid_ff),
      .in_value  (f_s_ff),
      .in_side   (f_blend_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---------------- stage G: magnitudes and rounded numerators
   logic [CW-1:0]           g_mag [4];
   logic [3:0][NW-1:0]      g_num_in;
   qnl_pkg::div_side_type   g_side_in;

   logic                    g_valid_ff;
   logic [CW-1:0]           g_root_ff;
   logic [3:0][NW-1:0]      g_num_ff;
   qnl_pkg::div_side_type   g_side_ff;

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         g_side_in.neg[n] = sq_side.comp[n][CW-1];
         g_mag[n] = sq_side.comp[n][CW-1] ? -sq_side.comp[n] : sq_side.comp[n];
         // c * 2^FRACTION_BITS + r/2, so the divide rounds to nearest
         g_num_in[n] = (NW'(g_mag[n]) << FRACTION_BITS) + NW'(sq_root >> 1);
      end
      g_side_in.degenerate = sq_side.degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      g_root_ff <= sq_root;
      g_num_ff  <= g_num_in;
      g_side_ff <= g_side_in;
   end

   // ---------------- normalize
   logic                    dv_valid;
   logic [3:0][Q-1:0]       dv_quot;
   qnl_pkg::div_side_type   dv_side;

   qnl_div #(
      .ROOT_WIDTH    (CW),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_valid_ff),
      .in_root   (g_root_ff),
      .in_num    (g_num_ff),
      .in_side   (g_side_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // ---------------- output: restore sign, identity on zero length
   logic [XW-1:0]       o_q   [4];
   logic [XW-1:0]       o_v   [4];
   qnl_pkg::rsp_type    o_data_in;

   logic                o_valid_ff;
   qnl_pkg::rsp_type    o_data_ff;

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         o_q[n] = XW'(dv_quot[n]);
         o_v[n] = dv_side.neg[n] ? -o_q[n] : o_q[n];
      end
      if (dv_side.degenerate) begin
         o_data_in.out_i = '0;
         o_data_in.out_j = '0;
         o_data_in.out_k = '0;
         o_data_in.out_w = IDENT_W;
      end else begin
         o_data_in.out_i = o_v[0][CW-1:0];
         o_data_in.out_j = o_v[1][CW-1:0];
         o_data_in.out_k = o_v[2][CW-1:0];
         o_data_in.out_w = o_v[3][CW-1:0];
      end
      o_data_in.degenerate = dv_side.degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      o_data_ff <= o_data_in;
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;

   // every result comes from an earlier accepted transfer, LATENCY back
   `QNL_ASSERT_IMP(a_rsp_from_req, clock, reset, rsp_valid, $past(start && !busy, LATENCY), "result without matching transfer")
   // identity flag tracks the zero squared length through sqrt and divide
   `QNL_ASSERT_IMP(a_degenerate_track, clock, reset, rsp_valid, rsp_data.degenerate == $past(f_s_ff == '0, F_TO_OUT), "degenerate flag lost its item")
   // stage A transfer shows up at the square-root input five stages later
   `QNL_ASSERT(a_front_valid, clock, reset, f_valid_ff == $past(accept, 6), "front pipeline valid slipped")

endmodule
